// File: src/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types, widths and codes for the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int MOM_W  = 24;            // breakpoint / query momentum
	localparam int EFF_W  = 17;            // Q1.16 efficiency
	localparam int QUO_W  = EFF_W;         // quotient magnitude never exceeds 1.0
	localparam int PROD_W = EFF_W + MOM_W; // |delta eff| * (q - x_lo)

	localparam int POINTS_DEF = 30;
	localparam int CURVES_DEF = 4;

	localparam logic [EFF_W-1:0] EFF_ONE = EFF_W'(65536);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [1:0] {
		REG_BELOW  = 2'd0,
		REG_INTERP = 2'd1,
		REG_ABOVE  = 2'd2
	} region_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LAST_RD,
		S_LAST_CHK,
		S_FIRST_RD,
		S_FIRST_CHK,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_MUL,
		S_DIV,
		S_OUT
	} state_t;

	typedef struct packed {
		logic             cmd;
		logic [1:0]       particle;
		logic [4:0]       point_index;
		logic [MOM_W-1:0] point_momentum;
		logic [EFF_W-1:0] point_efficiency;
		logic [MOM_W-1:0] query_momentum;
	} req_t;

	typedef struct packed {
		logic [EFF_W-1:0] efficiency;
		region_t          region;
	} rsp_t;

	typedef struct packed {
		logic [MOM_W-1:0] mom;
		logic [EFF_W-1:0] eff;
	} entry_t;

endpackage

// File: src/pli_mem.sv
// ----------------------------------------------------------------------------
// pli_mem
// Breakpoint store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pli_mem
	import pli_pkg::*;
#(
	parameter int DEPTH = POINTS_DEF * CURVES_DEF,
	parameter int AW    = $clog2(POINTS_DEF * CURVES_DEF)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: src/pli_div.sv
// ----------------------------------------------------------------------------
// pli_div
// Restoring divider, one quotient bit per cycle. Caller guarantees
// dividend < divisor << QUO_W, so only QUO_W steps are needed.
// ----------------------------------------------------------------------------
module pli_div
	import pli_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [MOM_W-1:0]  divisor,
	output logic              done,
	output logic [QUO_W-1:0]  quotient
);

	localparam int CW = $clog2(QUO_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [MOM_W-1:0] rem_q;
	logic [QUO_W-1:0] dvd_q;
	logic [QUO_W-1:0] quo_q;
	logic [MOM_W-1:0] den_q;

	logic [MOM_W:0] trial;
	logic [MOM_W:0] diff;
	logic           qbit;

	assign trial = {rem_q, dvd_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(QUO_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CW'(1);
			busy_q <= (cnt_q != CW'(1));
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[PROD_W-1:QUO_W];
			dvd_q <= dividend[QUO_W-1:0];
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[MOM_W-1:0] : trial[MOM_W-1:0];
			dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q != CW'(1) |=> busy_q || start)
		else $error("divider stopped early");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !$past(start) |-> rem_q < den_q)
		else $error("partial remainder not below divisor");

endmodule

// File: src/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Per-particle breakpoint curves with linear interpolation on query.
// ----------------------------------------------------------------------------
// Holds CURVES curves of POINTS breakpoints (momentum, Q1.16 efficiency) in
// one single-port-read memory. A load transfer writes one breakpoint and
// leaves the block idle and ready again right after, so loads stream at
// one per cycle while no query is in progress. Loaded efficiencies above
// 1.0 are stored as 1.0, and loads with an out-of-range curve or point
// number are dropped. A query transfer returns one result (queries to a
// curve number >= CURVES return nothing). A query reads the last and then
// the first breakpoint and checks each; then segments are scanned from the
// top down, one breakpoint read each; then a multiply state starts the
// bit-serial divider, and an output state loads the result register.
// Queries that land above the last breakpoint, or at or below the first,
// skip the scan, the multiply and the divide.
// req_ready is high only while the sequencer is idle; the result register
// lets the next transfer in while a finished result is still waiting.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator
	import pli_pkg::*;
#(
	parameter int POINTS = POINTS_DEF,
	parameter int CURVES = CURVES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int DEPTH = POINTS * CURVES;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(POINTS);

	// sequencer and datapath registers
	state_t           state_q, state_d;
	logic [MOM_W-1:0] q_q;           // query momentum
	logic [AW-1:0]    base_q;        // first entry of the selected curve
	logic [IW-1:0]    idx_q;         // scan position, lower end of segment
	entry_t           hi_q;          // upper breakpoint of the segment under test
	entry_t           lo_q;          // lower breakpoint once the segment is found
	logic             neg_q;         // slope sign
	logic [EFF_W-1:0] res_eff_q;
	region_t          res_region_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	// memory ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;

	// divider
	logic              div_start;
	logic              div_done;
	logic [QUO_W-1:0]  div_quo;
	logic [PROD_W-1:0] prod;
	logic [MOM_W-1:0]  den;

	logic req_xfer;
	logic rsp_free;
	logic curve_ok;
	logic point_ok;
	logic seg_hit;

	// slope and interpolation arithmetic
	logic signed [EFF_W:0]   ediff;
	logic [EFF_W-1:0]        emag;
	logic [MOM_W-1:0]        qdist;
	logic signed [EFF_W+1:0] interp;
	logic [EFF_W-1:0]        interp_sat;

	assign req_xfer = req_valid && req_ready;
	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign curve_ok = (32'(req.particle) < CURVES);
	assign point_ok = (32'(req.point_index) < POINTS);

	// load path: write straight from the transfer, saturating efficiency
	assign mem_we          = req_xfer && (req.cmd == CMD_LOAD) && curve_ok && point_ok;
	assign mem_waddr       = AW'(32'(req.particle) * POINTS + 32'(req.point_index));
	assign mem_wdata.mom   = req.point_momentum;
	assign mem_wdata.eff   = (req.point_efficiency > EFF_ONE) ? EFF_ONE
		: req.point_efficiency;

	// segment test: x_lo < q <= x_hi, lo being the word just read
	assign seg_hit = (mem_rdata.mom < q_q) && (q_q <= hi_q.mom);

	// slope magnitude times distance; the divider registers it
	assign ediff = $signed({1'b0, hi_q.eff}) - $signed({1'b0, lo_q.eff});
	assign emag  = ediff[EFF_W] ? EFF_W'(-ediff) : ediff[EFF_W-1:0];
	assign qdist = q_q - lo_q.mom;
	assign prod  = PROD_W'(emag) * PROD_W'(qdist);
	assign den   = hi_q.mom - lo_q.mom;

	// e_lo +/- quotient, truncated toward zero by working on magnitudes
	assign interp = neg_q ? ($signed({2'b00, lo_q.eff}) - $signed({2'b00, div_quo}))
		: ($signed({2'b00, lo_q.eff}) + $signed({2'b00, div_quo}));
	always_comb begin
		if (interp < 0) begin
			interp_sat = '0;
		end else if (interp > $signed({2'b00, EFF_ONE})) begin
			interp_sat = EFF_ONE;
		end else begin
			interp_sat = interp[EFF_W-1:0];
		end
	end

	pli_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	pli_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (den),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		div_start = 1'b0;
		mem_raddr = base_q;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_xfer && req.cmd == CMD_QUERY && curve_ok) begin
					state_d = S_LAST_RD;
				end
			end
			S_LAST_RD: begin
				mem_raddr = base_q + AW'(POINTS - 1);
				state_d   = S_LAST_CHK;
			end
			S_LAST_CHK: begin
				state_d = (q_q > mem_rdata.mom) ? S_OUT : S_FIRST_RD;
			end
			S_FIRST_RD: begin
				state_d = S_FIRST_CHK;
			end
			S_FIRST_CHK: begin
				state_d = (q_q <= mem_rdata.mom) ? S_OUT : S_SCAN_RD;
			end
			S_SCAN_RD: begin
				mem_raddr = base_q + AW'(idx_q);
				state_d   = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (seg_hit) begin
					state_d = S_MUL;
				end else if (idx_q == '0) begin
					state_d = S_OUT;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_MUL: begin
				div_start = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				q_q    <= req.query_momentum;
				base_q <= AW'(32'(req.particle) * POINTS);
			end
			S_LAST_CHK: begin
				hi_q         <= mem_rdata;
				res_eff_q    <= mem_rdata.eff;
				res_region_q <= REG_ABOVE;
			end
			S_FIRST_CHK: begin
				idx_q        <= IW'(POINTS - 2);
				res_eff_q    <= '0;
				res_region_q <= REG_BELOW;
			end
			S_SCAN_CHK: begin
				// scan goes downward, so the first hit is the highest segment
				res_region_q <= REG_INTERP;
				if (seg_hit) begin
					lo_q <= mem_rdata;
				end else begin
					hi_q  <= mem_rdata;
					idx_q <= idx_q - IW'(1);
				end
			end
			S_MUL: begin
				neg_q <= ediff[EFF_W];
			end
			S_DIV: begin
				if (div_done) begin
					res_eff_q <= interp_sat;
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_OUT && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && rsp_free) begin
			rsp_q.efficiency <= res_eff_q;
			rsp_q.region     <= res_region_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == S_IDLE)
		else $error("breakpoint write while a query is in progress");

	a_seg_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> (lo_q.mom < q_q) && (q_q <= hi_q.mom))
		else $error("interpolation segment does not bracket the query");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide wait");

	a_below_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.region == REG_BELOW |-> rsp_q.efficiency == '0)
		else $error("below-range result with nonzero efficiency");

	a_eff_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) && rsp_q.region == REG_INTERP |-> rsp_q.efficiency <= EFF_ONE)
		else $error("interpolated efficiency above one");

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the piecewise linear interpolator.
// ----------------------------------------------------------------------------
// Fills all four curves, then walks a short list of directed loads and
// queries. After that come three random phases with different idle mixes on
// the request and result channels. Each query's efficiency and region are
// predicted from a local copy of the breakpoint tables or, for some directed
// queries, typed in. Results are compared in order against the predictions.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pli_pkg::*;

	localparam int POINTS      = POINTS_DEF;
	localparam int CURVES      = CURVES_DEF;
	localparam int DIR_ROWS    = 24;
	localparam int HOLD_CYCLES = 400;  // long result stall, fills the block
	localparam int STALL_LIMIT = 3000; // cycles without any transfer
	localparam int TAIL_CYCLES = 120;  // idle tail after the last random phase
	localparam int MOM_MAX     = (1 << MOM_W) - 1;
	localparam int EFF_MAX     = (1 << EFF_W) - 1;
	localparam int ONE         = 65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	piecewise_linear_interpolator #(
		.POINTS(POINTS),
		.CURVES(CURVES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Local copy of the breakpoint memory. Every entry is loaded before the
	// first query, so no query ever touches an unwritten entry.
	logic [MOM_W-1:0] curve_mom [CURVES*POINTS];
	logic [EFF_W-1:0] curve_eff [CURVES*POINTS];

	rsp_t due_results [$]; // predicted results, oldest first

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 1'b0;   // asks the result side for one long stall
	int errors = 0;
	int n_loads = 0;
	int n_dropped = 0;
	int n_queries = 0;
	int n_below = 0;
	int n_interp = 0;
	int n_above = 0;

	// Directed list: expected result typed in only where it is obvious.
	typedef struct {
		logic             cmd;
		logic [1:0]       particle;
		logic [4:0]       idx;
		logic [MOM_W-1:0] mom;
		logic [EFF_W-1:0] eff;
		logic [MOM_W-1:0] q;
		bit               typed;
		logic [EFF_W-1:0] want_eff;
		region_t          want_reg;
	} plan_row_t;

	plan_row_t plan [DIR_ROWS];

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Efficiency of curve p at momentum q.
	function automatic rsp_t interp_lookup(input logic [1:0] p, input logic [MOM_W-1:0] q);
		int     base;
		int     last;
		int     seg;
		longint xlo, xhi, elo, ehi, r;
		rsp_t   res;
		base = int'(p) * POINTS;
		last = base + POINTS - 1;
		// above the last point wins even when the first point is higher
		if (q > curve_mom[last]) begin
			res.efficiency = curve_eff[last];
			res.region = REG_ABOVE;
			return res;
		end
		if (q <= curve_mom[base]) begin
			res.efficiency = '0;
			res.region = REG_BELOW;
			return res;
		end
		// several segments can bracket q on a non-monotonic curve: take the top one
		seg = -1;
		for (int k = 0; k < POINTS - 1; k++) begin
			if (q > curve_mom[base+k] && q <= curve_mom[base+k+1])
				seg = k;
		end
		res.region = REG_INTERP;
		if (seg < 0) begin
			res.efficiency = '0;
			return res;
		end
		xlo = longint'(curve_mom[base+seg]);
		xhi = longint'(curve_mom[base+seg+1]);
		elo = longint'(curve_eff[base+seg]);
		ehi = longint'(curve_eff[base+seg+1]);
		// signed division truncates toward zero
		r = elo + ((ehi - elo) * (longint'(q) - xlo)) / (xhi - xlo);
		if (r < 0)
			r = 0;
		if (r > ONE)
			r = ONE;
		res.efficiency = EFF_W'(r);
		return res;
	endfunction

	// Bookkeeping for one accepted request transfer.
	function automatic void book(input req_t r);
		int e;
		if (r.cmd == CMD_LOAD) begin
			// out-of-range point numbers are dropped by the block
			if (int'(r.point_index) < POINTS && int'(r.particle) < CURVES) begin
				e = int'(r.particle) * POINTS + int'(r.point_index);
				curve_mom[e] = r.point_momentum;
				curve_eff[e] = (r.point_efficiency > EFF_ONE) ? EFF_ONE : r.point_efficiency;
				n_loads++;
			end else begin
				n_dropped++;
			end
		end else if (int'(r.particle) < CURVES) begin
			due_results.push_back(interp_lookup(r.particle, r.query_momentum));
			n_queries++;
		end
	endfunction

	// Requests with random content in the fields the command does not use.
	function automatic req_t mk_load(input int p, input int idx, input int mom, input int eff);
		req_t r;
		r.cmd = CMD_LOAD;
		r.particle = 2'(p);
		r.point_index = 5'(idx);
		r.point_momentum = MOM_W'(mom);
		r.point_efficiency = EFF_W'(eff);
		r.query_momentum = MOM_W'($urandom);
		return r;
	endfunction

	function automatic req_t mk_query(input int p, input int q);
		req_t r;
		r.cmd = CMD_QUERY;
		r.particle = 2'(p);
		r.point_index = 5'($urandom);
		r.point_momentum = MOM_W'($urandom);
		r.point_efficiency = EFF_W'($urandom);
		r.query_momentum = MOM_W'(q);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// Offers one item and returns at the edge of its transfer. valid is left
	// high: the caller either offers the next item or drops valid in the same
	// step, so there is never a second transfer of the same payload.
	task automatic offer(input req_t item);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	// Sender pause: drop valid and wait for every predicted result.
	task automatic drain();
		req_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	// One random phase. Mostly queries spread over the live span of a curve,
	// some whole-curve rewrites with sorted momenta and random content, and a
	// few single loads anywhere as noise (including dropped point numbers).
	task automatic random_phase(input int items, input int s_pct, input int r_pct,
			input bit squeeze);
		int   done;
		int   pick;
		int   p;
		int   base;
		int   maxstep;
		int   x;
		int   e;
		int   ein;
		bit   falling;
		int   q;
		req_t r;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		if (squeeze)
			hold_req = 1'b1;
		done = 0;
		while (done < items) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				p = $urandom_range(0, CURVES - 1);
				case ($urandom_range(0, 3))
					0: maxstep = 3;
					1: maxstep = 200;
					2: maxstep = 20000;
					default: maxstep = 570000;
				endcase
				x = $urandom_range(0, MOM_MAX - (POINTS - 1) * maxstep);
				e = $urandom_range(0, ONE);
				falling = $urandom_range(0, 1);
				for (int i = 0; i < POINTS; i++) begin
					if ($urandom_range(0, 7) == 0) begin
						ein = $urandom_range(0, EFF_MAX); // may saturate
					end else begin
						ein = e;
					end
					r = mk_load(p, i, x, ein);
					offer(r);
					book(r);
					done++;
					x += $urandom_range(0, maxstep);
					e += falling ? -$urandom_range(0, 5000) : $urandom_range(0, 5000);
					if (e < 0)
						e = 0;
					if (e > ONE)
						e = ONE;
				end
			end else if (pick < 18) begin
				r = mk_load($urandom_range(0, CURVES - 1), $urandom_range(0, 31),
					$urandom, $urandom);
				offer(r);
				book(r);
				if (int'(r.point_index) < POINTS)
					done++;
			end else begin
				p = $urandom_range(0, CURVES - 1);
				base = p * POINTS;
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5:
						q = $urandom_range(int'(curve_mom[base]),
							int'(curve_mom[base+POINTS-1]));
					6: q = int'(curve_mom[base + $urandom_range(0, POINTS - 1)])
						+ $urandom_range(0, 2) - 1;
					7: q = $urandom_range(0, 1) ? 0 : MOM_MAX;
					default: q = $urandom;
				endcase
				r = mk_query(p, q);
				offer(r);
				book(r);
				done++;
			end
		end
		drain();
	endtask

	// ------------------------------------------------------------------------
	// Result side: random ready, one long stall on request, in-order check
	// ------------------------------------------------------------------------
	int hold_left = 0;

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result transfer with none expected: eff %0d region %0d",
						$time, rsp.efficiency, rsp.region);
					errors++;
				end else begin
					want = due_results.pop_front();
					case (want.region)
						REG_BELOW: n_below++;
						REG_INTERP: n_interp++;
						default: n_above++;
					endcase
					if (rsp.efficiency != want.efficiency || rsp.region != want.region) begin
						$display("%0t: mismatch: expected eff %0d region %0d, got eff %0d region %0d",
							$time, want.efficiency, want.region, rsp.efficiency, rsp.region);
						errors++;
					end
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: too long without a transfer on either channel ends the run.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding",
				$time, STALL_LIMIT, due_results.size());
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		req_t r;
		int   x;
		int   e;
		plan = '{
			// curve 0: x = 1000..30000 step 1000, e = 0..58000 step 2000
			'{CMD_QUERY, 2'd0, 5'd0, 24'd0, 17'd0, 24'd0, 1'b1, 17'd0, REG_BELOW},
			'{CMD_QUERY, 2'd0, 5'd0, 24'd0, 17'd0, 24'd1000, 1'b1, 17'd0, REG_BELOW},
			'{CMD_QUERY, 2'd0, 5'd0, 24'd0, 17'd0, 24'd30001, 1'b1, 17'd58000, REG_ABOVE},
			'{CMD_QUERY, 2'd0, 5'd0, 24'd0, 17'd0, 24'hFFFFFF, 1'b1, 17'd58000, REG_ABOVE},
			'{CMD_QUERY, 2'd0, 5'd0, 24'd0, 17'd0, 24'd30000, 1'b1, 17'd58000, REG_INTERP},
			'{CMD_QUERY, 2'd0, 5'd0, 24'd0, 17'd0, 24'd1001, 1'b0, 17'd0, REG_BELOW},
			'{CMD_QUERY, 2'd0, 5'd0, 24'd0, 17'd0, 24'd15500, 1'b0, 17'd0, REG_BELOW},
			// curve 1: falling efficiency, truncation toward zero
			'{CMD_QUERY, 2'd1, 5'd0, 24'd0, 17'd0, 24'd1050, 1'b0, 17'd0, REG_BELOW},
			'{CMD_QUERY, 2'd1, 5'd0, 24'd0, 17'd0, 24'd701, 1'b0, 17'd0, REG_BELOW},
			// curve 2: falling momenta, both end rules apply
			'{CMD_QUERY, 2'd2, 5'd0, 24'd0, 17'd0, 24'd5000, 1'b1, 17'd29000, REG_ABOVE},
			'{CMD_QUERY, 2'd2, 5'd0, 24'd0, 17'd0, 24'd1000, 1'b1, 17'd0, REG_BELOW},
			'{CMD_QUERY, 2'd2, 5'd0, 24'd0, 17'd0, 24'd0, 1'b1, 17'd0, REG_BELOW},
			// curve 3: overlapping segments, highest one wins
			'{CMD_QUERY, 2'd3, 5'd0, 24'd0, 17'd0, 24'd1200, 1'b0, 17'd0, REG_BELOW},
			'{CMD_QUERY, 2'd3, 5'd0, 24'd0, 17'd0, 24'd0, 1'b1, 17'd0, REG_BELOW},
			// top point at full scale, efficiency saturates to 1.0
			'{CMD_LOAD, 2'd3, 5'd29, 24'hFFFFFF, 17'h1FFFF, 24'd0, 1'b0, 17'd0, REG_BELOW},
			'{CMD_QUERY, 2'd3, 5'd0, 24'd0, 17'd0, 24'hFFFFFF, 1'b1, 17'd65536, REG_INTERP},
			'{CMD_QUERY, 2'd3, 5'd0, 24'd0, 17'd0, 24'd8000000, 1'b0, 17'd0, REG_BELOW},
			// point numbers past the curve are dropped
			'{CMD_LOAD, 2'd0, 5'd30, 24'd5, 17'd5, 24'd0, 1'b0, 17'd0, REG_BELOW},
			'{CMD_LOAD, 2'd0, 5'd31, 24'hFFFFFF, 17'h1FFFF, 24'd0, 1'b0, 17'd0, REG_BELOW},
			'{CMD_QUERY, 2'd0, 5'd0, 24'd0, 17'd0, 24'd30001, 1'b1, 17'd58000, REG_ABOVE},
			// just above 1.0 saturates too
			'{CMD_LOAD, 2'd2, 5'd0, 24'd0, 17'd65537, 24'd0, 1'b0, 17'd0, REG_BELOW},
			'{CMD_QUERY, 2'd2, 5'd0, 24'd0, 17'd0, 24'd500, 1'b0, 17'd0, REG_BELOW},
			'{CMD_LOAD, 2'd1, 5'd0, 24'd0, 17'd0, 24'd0, 1'b0, 17'd0, REG_BELOW},
			'{CMD_QUERY, 2'd1, 5'd0, 24'd0, 17'd0, 24'd1, 1'b0, 17'd0, REG_BELOW}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every curve with a fixed shape before any query
		for (int p = 0; p < CURVES; p++) begin
			for (int i = 0; i < POINTS; i++) begin
				case (p)
					0: begin x = 1000 * (i + 1); e = 2000 * i; end
					1: begin x = 700 * (i + 1); e = ONE - 2000 * i; end
					2: begin x = 30000 - 1000 * i; e = 1000 * i; end
					default: begin x = 1000 * (i / 2) + (i % 2) * 1500; e = 2000 * i; end
				endcase
				r = mk_load(p, i, x, e);
				offer(r);
				book(r);
			end
		end

		// directed list
		for (int n = 0; n < DIR_ROWS; n++) begin
			if (plan[n].cmd == CMD_LOAD)
				r = mk_load(plan[n].particle, plan[n].idx, plan[n].mom, plan[n].eff);
			else
				r = mk_query(plan[n].particle, plan[n].q);
			offer(r);
			if (plan[n].typed) begin
				due_results.push_back('{efficiency: plan[n].want_eff, region: plan[n].want_reg});
				n_queries++;
			end else begin
				book(r);
			end
		end
		drain();

		// random phases: busy sender / sparse receiver, the reverse, then none;
		// the last one opens with a long result stall
		random_phase(570, 8, 79, 1'b0);
		random_phase(570, 79, 8, 1'b0);
		random_phase(570, 0, 0, 1'b1);

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d loads (%0d dropped) and %0d queries over four curves.",
			n_loads, n_dropped, n_queries);
		$display("Results: %0d at or below first point, %0d interpolated, %0d above last.",
			n_below, n_interp, n_above);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
